>>> hdl/mbe_pkg.sv
// Shared types and constants for the mask boundary extractor.
// No dependencies; every other file of the block but mbe_ram imports this package.
`timescale 1ns / 1ps

package mbe_pkg;

   localparam int PIX_W      = 8;
   localparam int ROW_W      = 12;
   localparam int COL_W      = 12;
   localparam int CNT_W      = 25;
   localparam int LS_W       = 2;     // line store entry: {above was zero, pixel nonzero}
   localparam int LINE_DEPTH = 4096;
   localparam int LINE_AW    = 12;
   localparam int Q_DEPTH    = 4;
   localparam int Q_AW       = 2;
   localparam int CSR_AW     = 1;
   localparam int CSR_DW     = 12;

   localparam logic [CSR_AW-1:0] CSR_LAST_ROW = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_LAST_COL = 1'b1;

   // One classified item, handed from the front end to the back end.
   typedef struct packed {
      logic             dly_vld;   // result for the pixel one row up
      logic             dly_flag;
      logic             own_vld;   // result for this pixel (last row only)
      logic             own_flag;
      logic             end_row;   // column is the last of its row
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;       // row of the arriving pixel
   } mbe_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } mbe_qstat_type;

endpackage

>>> hdl/mbe_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Self-contained; read during write returns the old contents.
`timescale 1ns / 1ps

module mbe_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> hdl/mbe_front.sv
// Front end: accepts pixels, keeps the raster position and the line store,
// and classifies each item. Depends on mbe_pkg and mbe_ram.
`timescale 1ns / 1ps

module mbe_front
   import mbe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIX_W-1:0]     req_mask_pixel,
   input  logic [ROW_W-1:0]     last_row,
   input  logic [COL_W-1:0]     last_col,
   input  mbe_qstat_type        qstat,
   output logic                 push,
   output mbe_entry_type        push_entry
);

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [LS_W-1:0]  left_ff, left_in;
   logic [LS_W-1:0]  wdata_ff, wdata_in;
   logic             fwd_a_ff, fwd_a_in;
   logic             fwd_b_ff, fwd_b_in;

   logic             accept;
   logic             cur;
   logic [LS_W-1:0]  q_a, q_b;
   logic [LS_W-1:0]  old_bits, right_bits;
   logic             on_last_row, end_row, at_edge;
   logic [ROW_W-1:0] prev_row;
   logic [COL_W-1:0] next_col, next_col_p1;

   assign req_ready = !qstat.full;
   assign accept    = req_valid && req_ready;

   // Reads for the next column and the one right of it are issued as each
   // item is accepted; the entry just written is forwarded past the RAM.
   mbe_ram #(
      .WIDTH (LS_W),
      .DEPTH (LINE_DEPTH)
   ) u_line (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (col_ff[LINE_AW-1:0]),
      .wr_data   (wdata_in),
      .rd_en     (accept),
      .rd_addr_a (next_col[LINE_AW-1:0]),
      .rd_addr_b (next_col_p1[LINE_AW-1:0]),
      .rd_data_a (q_a),
      .rd_data_b (q_b)
   );

   always_comb begin
      cur         = |req_mask_pixel;
      old_bits    = fwd_a_ff ? wdata_ff : q_a;
      right_bits  = fwd_b_ff ? wdata_ff : q_b;
      on_last_row = row_ff >= last_row;
      end_row     = col_ff >= last_col;
      prev_row    = row_ff - ROW_W'(1);
      at_edge     = (prev_row == '0) || (col_ff == '0) || end_row || (prev_row >= last_row);

      push_entry.dly_vld  = row_ff != '0;
      push_entry.dly_flag = old_bits[0] &&
                            (at_edge || old_bits[1] || !left_ff[0] || !right_bits[0] || !cur);
      push_entry.own_vld  = on_last_row;
      push_entry.own_flag = cur;
      push_entry.end_row  = end_row;
      push_entry.col      = col_ff;
      push_entry.row      = row_ff;
      push = accept && (push_entry.dly_vld || push_entry.own_vld);

      wdata_in    = {~old_bits[0], cur};
      next_col    = end_row ? '0 : col_ff + COL_W'(1);
      next_col_p1 = next_col + COL_W'(1);
      fwd_a_in    = next_col == col_ff;
      fwd_b_in    = next_col_p1 == col_ff;
      col_in      = next_col;
      left_in     = (end_row && on_last_row) ? '0 : old_bits;
      if (end_row) begin
         row_in = on_last_row ? '0 : row_ff + ROW_W'(1);
      end else begin
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         left_ff  <= '0;
         fwd_a_ff <= 1'b0;
         fwd_b_ff <= 1'b0;
      end else if (accept) begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         left_ff  <= left_in;
         fwd_a_ff <= fwd_a_in;
         fwd_b_ff <= fwd_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         wdata_ff <= wdata_in;
      end
   end

endmodule

>>> hdl/mbe_queue.sv
// Short FIFO of classified items between front and back end.
// Depends on mbe_pkg.
`timescale 1ns / 1ps

module mbe_queue
   import mbe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  mbe_entry_type push_entry,
   input  logic          pop,
   output mbe_entry_type head,
   output mbe_qstat_type qstat
);

   mbe_entry_type   slot_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + Q_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
      qstat.full  = count_ff == (Q_AW+1)'(Q_DEPTH);
      qstat.empty = count_ff == '0;
      head        = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hdl/mbe_back.sv
// Back end: expands each queued item into one or two results, keeps the
// running boundary count and drives the result register. Depends on mbe_pkg.
`timescale 1ns / 1ps

module mbe_back
   import mbe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  mbe_entry_type    head,
   input  mbe_qstat_type    qstat,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_is_boundary,
   output logic [COL_W-1:0] rsp_col_index,
   output logic [ROW_W-1:0] rsp_row_index,
   output logic [CNT_W-1:0] rsp_boundary_count,
   output logic             rsp_last_of_run,
   output logic             rsp_end_of_frame
);

   typedef enum logic [1:0] {
      BK_FIRST  = 2'b01,
      BK_SECOND = 2'b10
   } bk_state_type;

   bk_state_type     state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;
   logic             flag_ff;
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [CNT_W-1:0] total_ff;
   logic             last_ff;
   logic             eof_ff;

   logic             load;
   logic             sel_dly;
   logic             sel_flag, sel_last, sel_eof;
   logic [ROW_W-1:0] sel_row;
   logic [CNT_W-1:0] cnt_sum;

   always_comb begin
      unique case (state_ff)
         BK_FIRST:  sel_dly = head.dly_vld;
         BK_SECOND: sel_dly = 1'b0;
         default:   sel_dly = 1'b0;
      endcase

      if (sel_dly) begin
         sel_flag = head.dly_flag;
         sel_row  = head.row - ROW_W'(1);
         sel_last = !head.own_vld;
         sel_eof  = 1'b0;
      end else begin
         sel_flag = head.own_flag;
         sel_row  = head.row;
         sel_last = 1'b1;
         sel_eof  = head.end_row;
      end

      load    = !qstat.empty && (!valid_ff || rsp_ready);
      pop     = load && sel_last;
      cnt_sum = cnt_ff + CNT_W'(sel_flag);

      if (!load) begin
         cnt_in = cnt_ff;
      end else if (pop && head.own_vld && head.end_row) begin
         cnt_in = '0;  // frame done
      end else begin
         cnt_in = cnt_sum;
      end

      if (!load) begin
         state_in = state_ff;
      end else if (pop) begin
         state_in = BK_FIRST;
      end else begin
         state_in = BK_SECOND;
      end

      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_FIRST;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         flag_ff  <= sel_flag;
         col_ff   <= head.col;
         row_ff   <= sel_row;
         total_ff <= cnt_sum;
         last_ff  <= sel_last;
         eof_ff   <= sel_eof;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_is_boundary    = flag_ff;
   assign rsp_col_index      = col_ff;
   assign rsp_row_index      = row_ff;
   assign rsp_boundary_count = total_ff;
   assign rsp_last_of_run    = last_ff;
   assign rsp_end_of_frame   = eof_ff;

endmodule

>>> hdl/mask_boundary_extract.sv
// Mask boundary extractor: 4-neighbour boundary points of a raster binary mask.
// Throughput: one pixel per cycle while the queue has room; a last-row pixel below row 0
// gives two results, so the result port, one result per cycle while rsp_ready holds,
// sets the rate on the last row. Results pass through the queue and the result register.
// Reset is synchronous: position, counts and queue clear; frame limits go to
// 4095; the line store is not cleared (row 0 never depends on its contents).
`timescale 1ns / 1ps

module mask_boundary_extract
   import mbe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // pixel input
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [PIX_W-1:0]  req_mask_pixel,
   // results
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_is_boundary,
   output logic [COL_W-1:0]  rsp_col_index,
   output logic [ROW_W-1:0]  rsp_row_index,
   output logic [CNT_W-1:0]  rsp_boundary_count,
   output logic              rsp_last_of_run,
   output logic              rsp_end_of_frame,
   // configuration writes
   input  logic              csr_wr_en,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wr_data
);

   logic [ROW_W-1:0] last_row_ff;
   logic [COL_W-1:0] last_col_ff;

   logic             push;
   logic             pop;
   mbe_entry_type    push_entry;
   mbe_entry_type    head;
   mbe_qstat_type    qstat;

   // Frame limits. To be written only while the block is idle; the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_row_ff <= '1;
         last_col_ff <= '1;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_LAST_ROW: last_row_ff <= csr_wr_data[ROW_W-1:0];
            CSR_LAST_COL: last_col_ff <= csr_wr_data[COL_W-1:0];
            default: ;
         endcase
      end
   end

   // Front end: raster position, line store with look-ahead reads, and the
   // neighbour test for the pixel one row up. Stalls only on a full queue.
   mbe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mask_pixel (req_mask_pixel),
      .last_row       (last_row_ff),
      .last_col       (last_col_ff),
      .qstat          (qstat),
      .push           (push),
      .push_entry     (push_entry)
   );

   // Four-item queue absorbs the extra result cycles of the last row.
   mbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   // Back end: one result per cycle into the output register while rsp_ready holds,
   // running count in emission order, cleared after the frame's last pixel.
   mbe_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .qstat              (qstat),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_boundary    (rsp_is_boundary),
      .rsp_col_index      (rsp_col_index),
      .rsp_row_index      (rsp_row_index),
      .rsp_boundary_count (rsp_boundary_count),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_end_of_frame   (rsp_end_of_frame)
   );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for mask_boundary_extract: streams raster mask frames,
// predicts every boundary verdict in step and checks each result field by field.
// Depends on hdl/mbe_pkg.sv and hdl/mask_boundary_extract.sv.
`timescale 1ns / 1ps

module testbench;
   import mbe_pkg::*;

   // One expected result: the verdict for one pixel position.
   typedef struct packed {
      logic             is_boundary;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [CNT_W-1:0] count;
      logic             last_of_run;
      logic             end_of_frame;
   } verdict_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [PIX_W-1:0]  req_mask_pixel = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_is_boundary;
   logic [COL_W-1:0]  rsp_col_index;
   logic [ROW_W-1:0]  rsp_row_index;
   logic [CNT_W-1:0]  rsp_boundary_count;
   logic              rsp_last_of_run;
   logic              rsp_end_of_frame;
   logic              csr_wr_en = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_wr_data = '0;

   mask_boundary_extract DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mask_pixel     (req_mask_pixel),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_boundary    (rsp_is_boundary),
      .rsp_col_index      (rsp_col_index),
      .rsp_row_index      (rsp_row_index),
      .rsp_boundary_count (rsp_boundary_count),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_end_of_frame   (rsp_end_of_frame),
      .csr_wr_en          (csr_wr_en),
      .csr_addr           (csr_addr),
      .csr_wr_data        (csr_wr_data)
   );

   // ---------------------------------------------------------------------
   // Shadow of the block: frame limits, raster position, line bits, count.
   // line_bits[c] = {pixel above the previous row's pixel was zero,
   //                 previous row's pixel nonzero}
   // ---------------------------------------------------------------------
   logic [ROW_W-1:0] lim_row = 12'hFFF;
   logic [COL_W-1:0] lim_col = 12'hFFF;
   logic [ROW_W-1:0] row_pos = '0;
   logic [COL_W-1:0] col_pos = '0;
   logic [LS_W-1:0]  line_bits [LINE_DEPTH];
   logic [LS_W-1:0]  left_bits = '0;
   logic [CNT_W-1:0] point_total = '0;

   verdict_type pixel_verdicts[$];   // verdicts still owed by the block
   int          error_count = 0;

   // sender burst state
   int burst_left = 0;

   // receiver stall state
   int stall_mode = 0;
   int stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      foreach (line_bits[i]) line_bits[i] = '0;
   end

   // Generous cap: the extreme frames plus the random part, with the slowest
   // receiver pattern, finish well inside this.
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   // Emits one verdict; on a boundary the count advances before the verdict is recorded.
   function automatic void post_verdict(input logic flag, input logic [COL_W-1:0] c,
                                        input logic [ROW_W-1:0] r, input logic last,
                                        input logic eof);
      verdict_type v;
      if (flag) point_total = point_total + 1'b1;
      v.is_boundary  = flag;
      v.col          = c;
      v.row          = r;
      v.count        = point_total;
      v.last_of_run  = last;
      v.end_of_frame = eof;
      pixel_verdicts.push_back(v);
   endfunction

   // Advances the shadow by one accepted pixel and queues the verdicts it frees.
   function automatic void classify_pixel(input logic [PIX_W-1:0] pix);
      logic             cur;
      logic [ROW_W-1:0] r;
      logic [ROW_W-1:0] pr;
      logic [COL_W-1:0] c;
      logic [COL_W-1:0] c_right;
      logic [LS_W-1:0]  above;
      logic             on_last;
      logic             end_row;
      logic             at_edge;
      logic             flag;
      cur     = (pix != 0);
      r       = row_pos;
      c       = col_pos;
      c_right = c + 1'b1;
      above   = line_bits[c];
      on_last = (r >= lim_row);
      end_row = (c >= lim_col);

      // pixel one row up: its lower neighbour has just arrived
      if (r > 0) begin
         pr      = r - 1'b1;
         at_edge = (pr == 0) || (c == 0) || end_row || (pr >= lim_row);
         flag    = above[0] && (at_edge || above[1] || !left_bits[0] ||
                                !line_bits[c_right][0] || !cur);
         post_verdict(flag, c, pr, !on_last, 1'b0);
      end
      // last row: the pixel is on the edge, so nonzero alone decides
      if (on_last) post_verdict(cur, c, r, 1'b1, end_row);

      line_bits[c] = {~above[0], cur};
      left_bits    = above;

      if (end_row) begin
         col_pos = '0;
         if (on_last) begin
            row_pos     = '0;
            point_total = '0;
            left_bits   = '0;
         end else begin
            row_pos = r + 1'b1;
         end
      end else begin
         col_pos = c + 1'b1;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Result side: check on each accepted result, then pick the next ready.
   // ---------------------------------------------------------------------
   task automatic check_verdict();
      verdict_type want;
      if (pixel_verdicts.size() == 0) begin
         report_mismatch($sformatf("unexpected result row %0d col %0d",
                                   rsp_row_index, rsp_col_index));
         return;
      end
      want = pixel_verdicts.pop_front();
      if (rsp_is_boundary !== want.is_boundary)
         report_mismatch($sformatf("is_boundary %b exp %b at (%0d,%0d)",
                         rsp_is_boundary, want.is_boundary, want.row, want.col));
      if (rsp_col_index !== want.col)
         report_mismatch($sformatf("col_index %0d exp %0d", rsp_col_index, want.col));
      if (rsp_row_index !== want.row)
         report_mismatch($sformatf("row_index %0d exp %0d", rsp_row_index, want.row));
      if (rsp_boundary_count !== want.count)
         report_mismatch($sformatf("boundary_count %0d exp %0d at (%0d,%0d)",
                         rsp_boundary_count, want.count, want.row, want.col));
      if (rsp_last_of_run !== want.last_of_run)
         report_mismatch($sformatf("last_of_run %b exp %b at (%0d,%0d)",
                         rsp_last_of_run, want.last_of_run, want.row, want.col));
      if (rsp_end_of_frame !== want.end_of_frame)
         report_mismatch($sformatf("end_of_frame %b exp %b at (%0d,%0d)",
                         rsp_end_of_frame, want.end_of_frame, want.row, want.col));
   endtask

   // Receiver: alternates between always-ready runs, coin-flip stalls and
   // heavy stalls (ready with odds of one in four), each for a random stretch.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_verdict();
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(5, 60);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // ---------------------------------------------------------------------
   // Pixel side
   // ---------------------------------------------------------------------

   // Sends one pixel and holds it until taken. Between bursts valid drops;
   // some bursts are long enough to stream with no gaps.
   task automatic push_pixel(input logic [PIX_W-1:0] pix);
      req_valid      <= 1'b1;
      req_mask_pixel <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      classify_pixel(pix);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 30);
      end
   endtask

   function automatic logic [PIX_W-1:0] rand_pixel(input int density);
      if ($urandom_range(0, 99) >= density) return '0;
      return ($urandom_range(0, 3) == 0) ? 8'hFF : PIX_W'($urandom_range(1, 255));
   endfunction

   // Waits until every owed verdict is in, then lets the pipe drain: a
   // first-row pixel owes nothing yet may still be in flight.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pixel_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] val);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_addr    <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      if (idx == CSR_LAST_ROW) lim_row = val;
      else lim_col = val;
   endtask

   // Sends random pixels until the raster position wraps to a new frame.
   task automatic finish_frame(input int density);
      do push_pixel(rand_pixel(density));
      while (row_pos != 0 || col_pos != 0);
   endtask

   task automatic set_frame(input int last_r, input int last_c);
      write_limit(CSR_LAST_ROW, CSR_DW'(last_r));
      write_limit(CSR_LAST_COL, CSR_DW'(last_c));
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset limits (4095 x 4095): first-row pixels owe nothing. Then both
   // limits shrink mid-frame below the current column, so the next pixel
   // ends row 0 and row 1 becomes the last row.
   task automatic test_reset_limits();
      push_pixel(8'h00);
      push_pixel(8'hFF);
      push_pixel(8'h01);
      set_frame(1, 2);
      push_pixel(8'h80);       // column 3, beyond the new limit: ends the row
      push_pixel(8'hFF);
      push_pixel(8'h00);
      push_pixel(8'h55);
   endtask

   // Single row: each pixel gives exactly its own verdict.
   task automatic test_single_row();
      set_frame(0, 2);
      push_pixel(8'h00);
      push_pixel(8'hAA);
      push_pixel(8'hFF);
   endtask

   // Single column: every pixel sits on the left and right edge.
   task automatic test_single_column();
      set_frame(2, 0);
      push_pixel(8'hFF);
      push_pixel(8'h00);
      push_pixel(8'h7F);
   endtask

   // 4 x 5 frame with interior holes: interior pixels with all neighbors set,
   // with a zero below, to the right, to the left and above.
   task automatic test_interior_holes();
      logic [PIX_W-1:0] pattern [20];
      pattern = '{8'hFF, 8'h01, 8'hFF, 8'h02, 8'hFF,
                  8'hFF, 8'h10, 8'h20, 8'h00, 8'hFF,
                  8'hFF, 8'h40, 8'h00, 8'h80, 8'hFF,
                  8'hFF, 8'hFF, 8'h04, 8'hFF, 8'h08};
      set_frame(3, 4);
      foreach (pattern[i]) push_pixel(pattern[i]);
   endtask

   // Register extremes: one-pixel frames, a full-width frame whose row is
   // cut short by a smaller column limit, and a full-height one-column frame
   // whose height is cut down below the current row.
   task automatic test_limit_extremes();
      set_frame(0, 0);
      repeat (4) push_pixel(rand_pixel(50));
      set_frame(1, 4095);
      repeat (25) push_pixel(rand_pixel(70));  // row 0, columns 0 to 24
      write_limit(CSR_LAST_COL, 12'd15);       // column 25 now ends row 0
      finish_frame(70);
      set_frame(4095, 0);
      repeat (30) push_pixel(rand_pixel(70));  // rows 0 to 29
      write_limit(CSR_LAST_ROW, 12'd20);       // row 30 now counts as last
      finish_frame(70);
   endtask

   // Limits grow and shrink in the middle of a frame; every column touched
   // here was written by the wide frame above.
   task automatic test_mid_frame_change();
      set_frame(4, 5);
      repeat (8) push_pixel(rand_pixel(75));   // stops at row 1, column 2
      write_limit(CSR_LAST_COL, 12'd9);
      repeat (10) push_pixel(rand_pixel(75));  // into row 2
      write_limit(CSR_LAST_ROW, 12'd1);        // row 2 now counts as last
      finish_frame(75);
   endtask

   // Random frames, mostly small, now and then wider or taller. Half the
   // time the frame streams straight on after the previous one.
   task automatic test_random_frames(input int pixel_goal);
      int sent;
      int last_r;
      int last_c;
      int density;
      sent = 0;
      while (sent < pixel_goal) begin
         if ($urandom_range(0, 1) == 0) begin
            last_r = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                 : $urandom_range(0, 6);
            last_c = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 12);
            set_frame(last_r, last_c);
         end
         density = $urandom_range(30, 95);
         do begin
            push_pixel(rand_pixel(density));
            sent++;
         end while (row_pos != 0 || col_pos != 0);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_limits();
      test_single_row();
      test_single_column();
      test_interior_holes();
      test_limit_extremes();
      test_mid_frame_change();
      test_random_frames(460);

      wait_idle();
      repeat (20) @(posedge clock);
      if (pixel_verdicts.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pixel_verdicts.size()));
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
